FILE: rtl/core/ccrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccrs_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_PRESENT = 3'd1,
    OP_MINRATE = 3'd2,
    OP_COLLECT = 3'd3,
    OP_RETURN  = 3'd4,
    OP_HANGUP  = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_HOLD    = 4'd1,
    PH_PATH    = 4'd2,
    PH_DWELL   = 4'd3,
    PH_RESTORE = 4'd4,
    PH_UNHOLD  = 4'd5,
    PH_HANGUP  = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    REG_RELAY_SETTLE   = 2'd0,
    REG_TEST_DWELL     = 2'd1,
    REG_COLLECT_RETURN = 2'd2,
    REG_HANGUP         = 2'd3
  } reg_idx_t;

  localparam logic POLARITY_POSITIVE = 1'b0;
  localparam logic POLARITY_NEGATIVE = 1'b1;

  localparam int unsigned TIME_W = 16;

  localparam logic [TIME_W-1:0] RELAY_SETTLE_RST   = 16'd10;
  localparam logic [TIME_W-1:0] TEST_DWELL_RST     = 16'd50;
  localparam logic [TIME_W-1:0] COLLECT_RETURN_RST = 16'd250;
  localparam logic [TIME_W-1:0] HANGUP_RST         = 16'd1000;

  typedef struct packed {
    logic phone_to_line;
    logic line_hold;
    logic polarity;
    logic test_voltage;
  } relays_t;

endpackage

`default_nettype wire

FILE: rtl/core/coin_control_relay_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Coin control relay sequencer: commands (test present, test minrate, collect,
// return, hangup) start a timed relay sequence that 1 ms tick items advance;
// a command that arrives while a sequence runs is answered with rejected set.
// Every input transfer yields exactly one result transfer. An item is
// accepted every clock cycle: the whole state update is one short step into
// the state registers and the result register, so the result appears in the
// cycle after acceptance, and in_tready only drops while the result register
// is full and out_tready is low. Configuration writes take effect at once and
// are meant to be issued while no result is pending.
module coin_control_relay_sequencer_core (
  input  wire         clk,
  input  wire         rst_n,
  // configuration
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_wdata,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [0] coin_sense, [7:1] zero
  input  wire  [2:0]  in_tuser,   // [2:0] operation
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata   // [0] relay_test_voltage, [1] relay_polarity,
                                  // [2] relay_line_hold, [3] relay_phone_to_line,
                                  // [4] busy_res, [5] done_res, [6] coin_result,
                                  // [7] rejected
);

  localparam int unsigned TW = ccrs_pkg::TIME_W;

  // configuration registers
  logic [TW-1:0] relay_settle_r, test_dwell_r, collect_return_r, hangup_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_settle_r   <= ccrs_pkg::RELAY_SETTLE_RST;
      test_dwell_r     <= ccrs_pkg::TEST_DWELL_RST;
      collect_return_r <= ccrs_pkg::COLLECT_RETURN_RST;
      hangup_r         <= ccrs_pkg::HANGUP_RST;
    end else if (cfg_we) begin
      case (ccrs_pkg::reg_idx_t'(cfg_index))
        ccrs_pkg::REG_RELAY_SETTLE:   relay_settle_r   <= cfg_wdata;
        ccrs_pkg::REG_TEST_DWELL:     test_dwell_r     <= cfg_wdata;
        ccrs_pkg::REG_COLLECT_RETURN: collect_return_r <= cfg_wdata;
        ccrs_pkg::REG_HANGUP:         hangup_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer state
  ccrs_pkg::phase_t  phase_r, phase_nxt;
  logic [TW-1:0]     countdown_r, countdown_nxt;
  ccrs_pkg::op_t     active_cmd_r, active_cmd_nxt;
  ccrs_pkg::relays_t relays_r, relays_nxt;
  logic              outcome_r, outcome_nxt;

  logic out_valid_r;
  logic [7:0] out_data_r, out_data_nxt;

  ccrs_pkg::op_t op;
  logic sense, accept, busy, is_cmd, cmd_ok, rej, wait_end, cmd_is_test, done;

  assign op        = ccrs_pkg::op_t'(in_tuser);
  assign sense     = in_tdata[0];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign busy        = (phase_r != ccrs_pkg::PH_IDLE);
  assign is_cmd      = (op inside {ccrs_pkg::OP_PRESENT, ccrs_pkg::OP_MINRATE,
                                   ccrs_pkg::OP_COLLECT, ccrs_pkg::OP_RETURN,
                                   ccrs_pkg::OP_HANGUP});
  assign cmd_ok      = is_cmd && !busy;
  assign rej         = is_cmd && busy;
  // a wait of zero ends on the first tick, same as a wait of one
  assign wait_end    = (op == ccrs_pkg::OP_TICK) && busy && (countdown_r <= TW'(1));
  assign cmd_is_test = (active_cmd_r inside {ccrs_pkg::OP_PRESENT, ccrs_pkg::OP_MINRATE});
  assign done        = wait_end && (phase_r == ccrs_pkg::PH_UNHOLD);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (cmd_ok) begin
      phase_nxt = (op == ccrs_pkg::OP_HANGUP) ? ccrs_pkg::PH_HANGUP : ccrs_pkg::PH_HOLD;
    end else if (wait_end) begin
      case (phase_r)
        ccrs_pkg::PH_HOLD:    phase_nxt = ccrs_pkg::PH_PATH;
        ccrs_pkg::PH_PATH:    phase_nxt = ccrs_pkg::PH_DWELL;
        ccrs_pkg::PH_DWELL:   phase_nxt = ccrs_pkg::PH_RESTORE;
        ccrs_pkg::PH_HANGUP:  phase_nxt = ccrs_pkg::PH_RESTORE;
        ccrs_pkg::PH_RESTORE: phase_nxt = ccrs_pkg::PH_UNHOLD;
        default:              phase_nxt = ccrs_pkg::PH_IDLE;
      endcase
    end
  end

  // timer, relays, test outcome and result word
  always_comb begin
    countdown_nxt  = countdown_r;
    active_cmd_nxt = active_cmd_r;
    relays_nxt     = relays_r;
    outcome_nxt    = outcome_r;

    if (cmd_ok) begin
      active_cmd_nxt = op;
      if (op == ccrs_pkg::OP_HANGUP) begin
        relays_nxt.line_hold     = 1'b0;
        relays_nxt.phone_to_line = 1'b0;
        countdown_nxt            = hangup_r;
      end else begin
        relays_nxt.test_voltage = (op == ccrs_pkg::OP_PRESENT) || (op == ccrs_pkg::OP_MINRATE);
        relays_nxt.polarity     = ((op == ccrs_pkg::OP_MINRATE) || (op == ccrs_pkg::OP_RETURN))
                                  ? ccrs_pkg::POLARITY_NEGATIVE : ccrs_pkg::POLARITY_POSITIVE;
        relays_nxt.line_hold    = 1'b1;
        countdown_nxt           = relay_settle_r;
      end
    end else if (wait_end) begin
      case (phase_r)
        ccrs_pkg::PH_HOLD: begin
          relays_nxt.phone_to_line = 1'b0;
          countdown_nxt            = relay_settle_r;
        end
        ccrs_pkg::PH_PATH: begin
          countdown_nxt = cmd_is_test ? test_dwell_r : collect_return_r;
        end
        ccrs_pkg::PH_DWELL, ccrs_pkg::PH_HANGUP: begin
          // opto is active low; only the dwell of a test samples it
          if (phase_r == ccrs_pkg::PH_DWELL && cmd_is_test) outcome_nxt = !sense;
          relays_nxt.test_voltage  = 1'b0;
          relays_nxt.polarity      = ccrs_pkg::POLARITY_POSITIVE;
          relays_nxt.phone_to_line = 1'b1;
          countdown_nxt            = relay_settle_r;
        end
        ccrs_pkg::PH_RESTORE: begin
          relays_nxt.line_hold = 1'b0;
          countdown_nxt        = relay_settle_r;
        end
        default: countdown_nxt = '0;
      endcase
    end else if ((op == ccrs_pkg::OP_TICK) && busy) begin
      countdown_nxt = countdown_r - TW'(1);
    end

    out_data_nxt = {rej, outcome_nxt, done, (phase_nxt != ccrs_pkg::PH_IDLE),
                    relays_nxt.phone_to_line, relays_nxt.line_hold,
                    relays_nxt.polarity, relays_nxt.test_voltage};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ccrs_pkg::PH_IDLE;
      countdown_r  <= '0;
      active_cmd_r <= ccrs_pkg::OP_TICK;
      relays_r     <= '{phone_to_line: 1'b1, line_hold: 1'b0,
                        polarity: 1'b0, test_voltage: 1'b0};
      outcome_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        phase_r      <= phase_nxt;
        countdown_r  <= countdown_nxt;
        active_cmd_r <= active_cmd_nxt;
        relays_r     <= relays_nxt;
        outcome_r    <= outcome_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ccrs_pkg::PH_IDLE) |-> (countdown_r == '0))
    else $error("timer not clear while idle");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[5]) |-> (!out_data_r[4] && !out_data_r[7]))
    else $error("done result still busy or rejected");

  a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[7]) |-> out_data_r[4])
    else $error("reject reported while idle");

  a_state_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[4] == (phase_r != ccrs_pkg::PH_IDLE)))
    else $error("busy flag disagrees with phase");

  a_hold_when_path: assert property (@(posedge clk) disable iff (!rst_n)
    !relays_r.phone_to_line |-> (phase_r != ccrs_pkg::PH_IDLE))
    else $error("coin path left connected while idle");

endmodule

`default_nettype wire
